// ===== sv/rgb_hsl_pkg.sv =====
// rgb_hsl_pkg: request types and fixed widths for the rgb to hsl converter
// no dependencies
package rgb_hsl_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned FIELD_W = 16;
  // divider operand widths: numerator stays below 6*255, shifted remainder below 2*1530
  localparam int unsigned DEN_W = 11;
  localparam int unsigned REM_W = 12;
  localparam int unsigned NUM_LANES = 2;
  localparam int unsigned LANE_HUE = 0;
  localparam int unsigned LANE_SAT = 1;

  // lightness: sum * 2^(FRAC_BITS-1) / 255 split into sum * whole part plus a
  // small remainder term, which is divided by 255 through a reciprocal that is
  // exact for every value below 2^LIT_W
  localparam int unsigned LIT_W = 17;
  localparam int unsigned LIT_ROUND = 127;
  localparam int unsigned LIT_RECIP = 131587;
  localparam int unsigned LIT_RECIP_W = 18;
  localparam int unsigned LIT_SHIFT = 25;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_rgb_t;

  typedef struct packed {
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] lightness;
  } pixel_hsl_t;

endpackage

// ===== sv/rgb_to_hsl_converter.sv =====
// rgb_to_hsl_converter: pipelined rgb to hsl conversion, one pixel per clock while out_ready is high
// depends on rgb_hsl_pkg
//
//   channel | signals                      | payload
//   --------+------------------------------+--------------------------
//   in      | in_valid, in_ready           | rgb_hsl_pkg::pixel_rgb_t
//   out     | out_valid, out_ready         | rgb_hsl_pkg::pixel_hsl_t
//
// pipeline: one setup stage, FRAC_BITS + 2 restoring
// divider stages (one quotient bit each, hue and saturation side by side;
// lightness by reciprocal multiply in the first two, then carried along),
// one rounding stage; throughput is one request per clock while out_ready is high
// each stage moves when its successor is empty or moving, so bubbles are
// squeezed out and a stalled output still lets upstream stages fill
// reset clears the valid bits only
module rgb_to_hsl_converter #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rgb_hsl_pkg::pixel_rgb_t in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rgb_hsl_pkg::pixel_hsl_t out_data
);

  localparam int unsigned NS = FRAC_BITS + 2;     // divider steps = quotient bits
  localparam int unsigned QB = FRAC_BITS + 2;
  localparam int unsigned LAST = NS + 1;          // rounding / output stage
  localparam int unsigned OW = (QB > rgb_hsl_pkg::FIELD_W) ? QB : rgb_hsl_pkg::FIELD_W;
  localparam int unsigned RW = rgb_hsl_pkg::REM_W;
  localparam int unsigned DW = rgb_hsl_pkg::DEN_W;
  localparam int unsigned NL = rgb_hsl_pkg::NUM_LANES;
  localparam int unsigned LW = rgb_hsl_pkg::LIT_W;
  localparam int unsigned PW = rgb_hsl_pkg::LIT_W + rgb_hsl_pkg::LIT_RECIP_W;
  // 2^(FRAC_BITS-1) = 255 * LIT_A + LIT_B
  localparam int unsigned LIT_A = (32'd1 << (FRAC_BITS - 1)) / 255;
  localparam int unsigned LIT_B = (32'd1 << (FRAC_BITS - 1)) % 255;

  // per-stage valid and handshake chain
  logic [LAST:0] valid;
  logic [LAST:0] can_load;
  logic [LAST:0] moves;

  // divider pipeline storage, stage 0 is the setup result
  logic [RW-1:0] rem [0:NS][NL];
  logic [DW-1:0] den [0:NS][NL];
  logic [QB-1:0] quo [0:NS][NL];

  // lightness path: sum at stage 0, remainder term at stage 1, value after
  logic [9:0]    lit_sum;
  logic [LW-1:0] lit_w;
  logic [QB-1:0] lit_q [1:NS];

  rgb_hsl_pkg::pixel_hsl_t result;

  // backward ready chain
  always_comb begin
    moves[LAST]    = valid[LAST] & out_ready;
    can_load[LAST] = ~valid[LAST] | moves[LAST];
    for (int k = LAST - 1; k >= 0; k--) begin
      moves[k]    = valid[k] & can_load[k+1];
      can_load[k] = ~valid[k] | moves[k];
    end
  end

  assign in_ready  = can_load[0];
  assign out_valid = valid[LAST];
  assign out_data  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (can_load[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (can_load[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // setup: max, min, and the numerator / denominator of each fraction
  logic [8:0]  mx, mn, dlt;
  logic [9:0]  sum;
  logic signed [12:0] hnum;
  logic [RW-1:0] set_num [NL];
  logic [DW-1:0] set_den [NL];

  always_comb begin
    logic [8:0] r, g, b;
    r = {1'b0, in_data.red};
    g = {1'b0, in_data.green};
    b = {1'b0, in_data.blue};
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dlt = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    // hue numerator, red wins ties, then green
    if (r == mx) begin
      hnum = 13'(signed'({4'b0, g})) - 13'(signed'({4'b0, b}));
    end else if (g == mx) begin
      hnum = 13'(signed'({3'b0, dlt, 1'b0})) + 13'(signed'({4'b0, b}))
           - 13'(signed'({4'b0, r}));
    end else begin
      hnum = 13'(signed'({2'b0, dlt, 2'b0})) + 13'(signed'({4'b0, r}))
           - 13'(signed'({4'b0, g}));
    end
    if (hnum < 0) hnum = hnum + 13'(signed'({4'b0, dlt}) * 13'sd6);

    if (dlt == '0) begin
      // grey pixel: hue and saturation forced to zero
      set_num[rgb_hsl_pkg::LANE_HUE] = '0;
      set_den[rgb_hsl_pkg::LANE_HUE] = DW'(1);
      set_num[rgb_hsl_pkg::LANE_SAT] = '0;
      set_den[rgb_hsl_pkg::LANE_SAT] = DW'(1);
    end else begin
      set_num[rgb_hsl_pkg::LANE_HUE] = RW'(hnum);
      set_den[rgb_hsl_pkg::LANE_HUE] = DW'({2'b0, dlt} * 11'd6);
      set_num[rgb_hsl_pkg::LANE_SAT] = RW'(dlt);
      if (sum < 10'd255) begin
        set_den[rgb_hsl_pkg::LANE_SAT] = DW'(sum);
      end else begin
        set_den[rgb_hsl_pkg::LANE_SAT] = DW'(10'd510 - sum);
      end
    end
  end

  // stage 0 capture and divider stages, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (can_load[0]) begin
      for (int l = 0; l < NL; l++) begin
        rem[0][l] <= set_num[l];
        den[0][l] <= set_den[l];
        quo[0][l] <= '0;
      end
    end
    for (int k = 1; k <= NS; k++) begin
      if (can_load[k]) begin
        for (int l = 0; l < NL; l++) begin
          logic [RW-1:0] t;
          // first step yields the integer bit, later steps shift first
          t = (k == 1) ? rem[k-1][l] : {rem[k-1][l][RW-2:0], 1'b0};
          den[k][l] <= den[k-1][l];
          if (t >= RW'(den[k-1][l])) begin
            rem[k][l] <= t - RW'(den[k-1][l]);
            quo[k][l] <= {quo[k-1][l][QB-2:0], 1'b1};
          end else begin
            rem[k][l] <= t;
            quo[k][l] <= {quo[k-1][l][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // lightness = sum * LIT_A + floor((sum * LIT_B + 127) / 255), never above 1.0
  always_ff @(posedge clk) begin
    if (can_load[0]) begin
      lit_sum <= sum;
    end
    if (can_load[1]) begin
      lit_w    <= LW'(lit_sum) * LW'(LIT_B) + LW'(rgb_hsl_pkg::LIT_ROUND);
      lit_q[1] <= QB'(lit_sum) * QB'(LIT_A);
    end
    if (can_load[2]) begin
      lit_q[2] <= lit_q[1]
                + QB'((PW'(lit_w) * PW'(rgb_hsl_pkg::LIT_RECIP)) >> rgb_hsl_pkg::LIT_SHIFT);
    end
    for (int k = 3; k <= NS; k++) begin
      if (can_load[k]) begin
        lit_q[k] <= lit_q[k-1];
      end
    end
  end

  // rounding stage: half-up rounding of the extra quotient bit, clamp at 1.0
  always_ff @(posedge clk) begin
    if (can_load[LAST]) begin
      logic [QB-1:0] rq [NL];
      logic [OW-1:0] ext [NL];
      logic [OW-1:0] ext_lit;
      for (int l = 0; l < NL; l++) begin
        rq[l] = QB'(({1'b0, quo[NS][l]} + {{QB{1'b0}}, 1'b1}) >> 1);
        if (rq[l] > (QB'(1) << FRAC_BITS)) rq[l] = QB'(1) << FRAC_BITS;
        ext[l] = OW'(rq[l]);
      end
      ext_lit = OW'(lit_q[NS]);
      result.hue        <= ext[rgb_hsl_pkg::LANE_HUE][rgb_hsl_pkg::FIELD_W-1:0];
      result.saturation <= ext[rgb_hsl_pkg::LANE_SAT][rgb_hsl_pkg::FIELD_W-1:0];
      result.lightness  <= ext_lit[rgb_hsl_pkg::FIELD_W-1:0];
    end
  end

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for rgb_to_hsl_converter
// depends on rgb_hsl_pkg and rgb_to_hsl_converter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = 15;
  localparam int unsigned LATENCY = FRAC + 4;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  rgb_hsl_pkg::pixel_rgb_t in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  rgb_hsl_pkg::pixel_hsl_t out_data;

  rgb_hsl_pkg::pixel_hsl_t expected_hsl[$];
  int         error_count = 0;
  bit         rx_stall_on = 1'b1;

  always #2 clk = ~clk;

  rgb_to_hsl_converter #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // round(num * 2^FRAC / den), ties up, clamped at 1.0
  function automatic logic [63:0] to_fraction(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = ((num << (FRAC + 1)) + den) / (den * 2);
    if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
    return q;
  endfunction

  function automatic rgb_hsl_pkg::pixel_hsl_t convert_pixel(rgb_hsl_pkg::pixel_rgb_t px);
    rgb_hsl_pkg::pixel_hsl_t res;
    longint r, g, b, hi, lo, span, total, num;
    r = longint'(px.red); g = longint'(px.green); b = longint'(px.blue);
    hi = r; lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span = hi - lo;
    total = hi + lo;
    res = '0;
    res.lightness = 16'(to_fraction(unsigned'(total), 510));
    // grey pixel keeps hue and saturation at zero
    if (span != 0) begin
      if (total < 255) res.saturation = 16'(to_fraction(unsigned'(span), unsigned'(total)));
      else res.saturation = 16'(to_fraction(unsigned'(span), unsigned'(510 - total)));
      // red wins ties, then green
      if (r == hi) num = g - b;
      else if (g == hi) num = 2 * span + (b - r);
      else num = 4 * span + (r - g);
      if (num < 0) num += 6 * span;
      res.hue = 16'(to_fraction(unsigned'(num), unsigned'(6 * span)));
    end
    return res;
  endfunction

  // one request: valid held until accepted, left high for a following request
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rgb_hsl_pkg::pixel_rgb_t px;
    px.red = r; px.green = g; px.blue = b;
    in_data <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_hsl.push_back(convert_pixel(px));
    @(negedge clk);
  endtask

  // random bursts; the valid stays up across back-to-back requests
  task automatic send_random_burst(int count, bit skew_grey);
    rgb_hsl_pkg::pixel_rgb_t px;
    int gap;
    for (int i = 0; i < count; i++) begin
      px = rgb_hsl_pkg::pixel_rgb_t'(24'($urandom));
      if (skew_grey && $urandom_range(0, 3) == 0) begin
        // ties and grey levels
        px.green = px.red;
        if ($urandom_range(0, 1)) px.blue = px.red;
      end
      send_pixel(px.red, px.green, px.blue);
      if (i != count - 1 && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    while (expected_hsl.size() != 0) @(negedge clk);
  endtask

  task automatic test_extremes();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);   // hue just under a full turn
    send_pixel(8'd255, 8'd255, 8'd0); // red and green tie
    send_pixel(8'd0, 8'd255, 8'd255); // green and blue tie
    send_pixel(8'd255, 8'd0, 8'd255); // red and blue tie
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd127, 8'd128, 8'd0); // max plus min is 128, lightness just over a quarter
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd10, 8'd200, 8'd100);
    send_pixel(8'd90, 8'd30, 8'd250);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    for (int k = 0; k < 6; k++) send_random_burst(50, 1'b1);
    // hold off until the pipe is empty, then refill from cold
    in_valid <= 1'b0;
    wait_drained();
    rx_stall_on = 1'b0;
    send_random_burst(150, 1'b0);
    rx_stall_on = 1'b1;
    send_random_burst(150, 1'b0);
    in_valid <= 1'b0;
  endtask

  // receiver drops ready at random while rx_stall_on is set, else always ready
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) begin
        @(negedge clk);
        out_ready <= rx_stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    rgb_hsl_pkg::pixel_hsl_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_hsl.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_hsl.pop_front();
        if (out_data.hue !== want.hue) begin
          $display("%0t: hue expected %0d actual %0d", $time, want.hue, out_data.hue);
          error_count++;
        end
        if (out_data.saturation !== want.saturation) begin
          $display("%0t: saturation expected %0d actual %0d", $time,
                   want.saturation, out_data.saturation);
          error_count++;
        end
        if (out_data.lightness !== want.lightness) begin
          $display("%0t: lightness expected %0d actual %0d", $time,
                   want.lightness, out_data.lightness);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_random();
    wait_drained();
    repeat (LATENCY * 2) @(negedge clk);
    if (error_count == 0 && expected_hsl.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400us;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
